### rtl/core/assert_macros.svh
// assertion helpers, compiled out with NO_ASSERTIONS
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("invariant failed");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_ALWAYS(lbl, clk, rst_n, cond)

`endif

`endif

### rtl/core/ibt_pkg.sv
package ibt_pkg;

  typedef enum logic [1:0] {
    FUNC_CHECK    = 2'd0,
    FUNC_APPEND   = 2'd1,
    FUNC_DEL_SAME = 2'd2,
    FUNC_DEL_NUM  = 2'd3
  } ibt_func_e;

  typedef enum logic [2:0] {
    KIND_EXACT   = 3'd0,
    KIND_WILD    = 3'd1,
    KIND_RANGE   = 3'd2,
    KIND_NETMASK = 3'd3,
    KIND_PREFIX  = 3'd4
  } ibt_kind_e;

  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_NOT_BANNED = 3'd1;
  localparam logic [2:0] ST_BANNED     = 3'd2;
  localparam logic [2:0] ST_ERROR      = 3'd3;
  localparam logic [2:0] ST_NO_MATCH   = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;
  localparam logic [2:0] ST_BAD_NUMBER = 3'd6;

  localparam logic [5:0] PREFIX_MAX = 6'd32;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_DONE = 2'd2
  } ibt_state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] first;
    logic [31:0] second;
    logic [5:0]  prefix;
    logic [3:0]  wild;
    logic [31:0] expiry;
  } rule_t;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic expired;
    logic hit;
    logic err;
    logic same;
  } eval_t;

  function automatic logic [31:0] wild_keep_mask(input logic [3:0] wild);
    logic [31:0] m;
    m = 32'd0;
    for (int o = 0; o < 4; o++) begin
      if (!wild[3-o]) m[31-8*o -: 8] = 8'hFF;
    end
    return m;
  endfunction

endpackage

### rtl/core/ibt_cell.sv
module ibt_cell
  import ibt_pkg::*;
(
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  rule_t      next_rule_i,
  input  rule_t      ins_rule_i,
  output rule_t      rule_o
);

  rule_t rule_q, rule_d;

  always_comb begin
    rule_d = rule_q;
    if (ctrl_i.load) begin
      rule_d = ins_rule_i;
    end else if (ctrl_i.shift) begin
      rule_d = next_rule_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rule_q <= rule_d;
  end

  assign rule_o = rule_q;

endmodule

### rtl/core/ibt_eval.sv
module ibt_eval
  import ibt_pkg::*;
(
  input  rule_t       head_i,
  input  rule_t       key_i,
  input  logic [31:0] addr_i,
  input  logic [31:0] now_i,
  output eval_t       eval_o
);

  logic [31:0] wmask_head, wmask_key, pmask;

  always_comb begin
    wmask_head = wild_keep_mask(head_i.wild);
    wmask_key  = wild_keep_mask(key_i.wild);
    // shifts of 32 or more give zero, so prefix 32 or more compares all bits; prefix 0 none
    pmask      = ~(32'hFFFF_FFFF >> head_i.prefix);

    eval_o.expired = (head_i.expiry != 32'd0) && (head_i.expiry <= now_i);
    eval_o.hit  = 1'b0;
    eval_o.err  = 1'b0;
    eval_o.same = 1'b0;
    case (head_i.kind)
      KIND_EXACT: begin
        eval_o.hit  = addr_i == head_i.first;
        eval_o.same = key_i.first == head_i.first;
      end
      KIND_WILD: begin
        eval_o.hit  = (addr_i & wmask_head) == (head_i.first & wmask_head);
        eval_o.same = (key_i.wild == head_i.wild)
                   && ((key_i.first & wmask_key) == (head_i.first & wmask_key));
      end
      KIND_RANGE: begin
        eval_o.hit  = (addr_i >= head_i.first) && (addr_i <= head_i.second);
        eval_o.same = (key_i.first == head_i.first) && (key_i.second == head_i.second);
      end
      KIND_NETMASK: begin
        eval_o.err  = (addr_i == 32'd0) || (head_i.first == 32'd0)
                   || (head_i.second == 32'd0);
        eval_o.hit  = (addr_i & head_i.second) == (head_i.first & head_i.second);
        eval_o.same = (key_i.first == head_i.first) && (key_i.second == head_i.second);
      end
      KIND_PREFIX: begin
        eval_o.err  = (addr_i == 32'd0) || (head_i.first == 32'd0);
        eval_o.hit  = (addr_i & pmask) == (head_i.first & pmask);
        eval_o.same = (key_i.first == head_i.first) && (key_i.prefix == head_i.prefix);
      end
      default: begin
        eval_o.hit = 1'b0;
      end
    endcase
    if (key_i.kind != head_i.kind) eval_o.same = 1'b0;
  end

endmodule

### rtl/core/ipv4_first_match_ban_table.sv
// IPv4 first-match ban table.
// Input channel (in_valid_i / in_stall_o) carries one operation per transfer:
// check an address, append a rule, delete identical rules or delete by number.
// Output channel (out_valid_o / out_stall_i) returns one result per operation:
// status, matching rule number and removed count.
// Config channel (cfg_valid_i / cfg_ready_o) writes check_interval; always ready.
// Rules live in a chain of cells; cell 0 is the head. Check and both deletes
// pop the head once per cycle and either rewrite it behind the kept rules or
// drop it, so the table stays ordered and compact after one pass.
// Append, rejected operations and operations on an empty table go straight to the
// done state; otherwise check and deletes first walk every rule in the table.
// The next transfer is taken only once the result is in the output register, so
// operations never overlap. The output register holds the result while
// out_stall_i is high. Reset empties the table, clears last purge time and interval.
module ipv4_first_match_ban_table
  import ibt_pkg::*;
#(
  parameter int TABLE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] address_i,
  input  logic [2:0]  rule_kind_i,
  input  logic [31:0] first_addr_i,
  input  logic [31:0] second_addr_i,
  input  logic [5:0]  prefix_length_i,
  input  logic [3:0]  any_octet_i,
  input  logic [31:0] expire_time_i,
  input  logic [5:0]  entry_number_i,
  input  logic [31:0] time_now_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [5:0]  rule_number_o,
  output logic [5:0]  removed_count_o
);

`include "assert_macros.svh"

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  ibt_state_e  state_q, state_d;
  logic [CW-1:0] count_q, count_d, rem_q, rem_d, kept_q, kept_d;
  logic [CW-1:0] pos_q, pos_d, removed_q, removed_d, res_num_q, res_num_d;
  logic [31:0] interval_q, last_purge_q, last_purge_d;
  logic [1:0]  func_q, func_d;
  logic [31:0] addr_q, addr_d, now_q, now_d;
  logic [5:0]  num_q, num_d;
  rule_t       key_q, key_d, in_rule;
  logic        purge_q, purge_d, found_q, found_d;
  logic [2:0]  res_status_q, res_status_d;
  logic        out_valid_q, out_valid_d;
  logic [2:0]  status_q, status_d;
  logic [5:0]  rnum_q, rnum_d, rcnt_q, rcnt_d;

  logic        accept, walking, keep, do_append, out_load, bad_rule;
  logic [CW-1:0] ins_idx;
  rule_t       cell_rule [TABLE_DEPTH];
  rule_t       ins_rule;
  eval_t       ev;
  logic [2:0]  fin_status;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = state_q != S_IDLE;
  assign accept      = in_valid_i && !in_stall_o;
  assign walking     = state_q == S_WALK;
  assign out_load    = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  assign in_rule = '{kind: rule_kind_i, first: first_addr_i, second: second_addr_i,
                     prefix: prefix_length_i, wild: any_octet_i, expiry: expire_time_i};
  assign bad_rule = (rule_kind_i > KIND_PREFIX)
                 || ((rule_kind_i == KIND_PREFIX) && (prefix_length_i > PREFIX_MAX));
  assign do_append = accept && (func_i == FUNC_APPEND) && !bad_rule
                  && (32'(count_q) < TABLE_DEPTH);

  ibt_eval u_eval (
    .head_i (cell_rule[0]),
    .key_i  (key_q),
    .addr_i (addr_q),
    .now_i  (now_q),
    .eval_o (ev)
  );

  always_comb begin
    case (func_q)
      FUNC_CHECK:    keep = !(purge_q && ev.expired);
      FUNC_DEL_SAME: keep = !ev.same;
      FUNC_DEL_NUM:  keep = (32'(pos_q) + 32'd1) != 32'(num_q);
      default:       keep = 1'b1;
    endcase
  end

  // kept rules sit right behind the unexamined ones after each shift
  assign ins_idx  = rem_q + kept_q - CW'(1);
  assign ins_rule = walking ? cell_rule[0] : in_rule;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    rule_t      next_rule;
    assign ctrl = '{shift: walking,
                    load: (walking && keep && (ins_idx == CW'(i)))
                          || (do_append && (count_q == CW'(i)))};
    if (i < TABLE_DEPTH - 1) begin : g_mid
      assign next_rule = cell_rule[i+1];
    end else begin : g_last
      assign next_rule = cell_rule[i];
    end
    ibt_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .next_rule_i (next_rule),
      .ins_rule_i  (ins_rule),
      .rule_o      (cell_rule[i])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (func_i == FUNC_CHECK && count_q != '0) state_d = S_WALK;
          else if (func_i == FUNC_DEL_SAME && !bad_rule && count_q != '0) state_d = S_WALK;
          else if (func_i == FUNC_DEL_NUM && entry_number_i != 6'd0
                   && 32'(entry_number_i) <= 32'(count_q)) state_d = S_WALK;
          else state_d = S_DONE;
        end
      end
      S_WALK: begin
        if (rem_q == CW'(1)) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    case (func_q)
      FUNC_CHECK:    fin_status = found_q ? res_status_q : ST_NOT_BANNED;
      FUNC_DEL_SAME: fin_status = found_q ? res_status_q
                                : (removed_q != '0 ? ST_DONE : ST_NO_MATCH);
      default:       fin_status = res_status_q;
    endcase
  end

  // datapath
  always_comb begin
    count_d      = count_q;
    rem_d        = rem_q;
    kept_d       = kept_q;
    pos_d        = pos_q;
    removed_d    = removed_q;
    res_num_d    = res_num_q;
    last_purge_d = last_purge_q;
    func_d       = func_q;
    addr_d       = addr_q;
    now_d        = now_q;
    num_d        = num_q;
    key_d        = key_q;
    purge_d      = purge_q;
    found_d      = found_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    status_d     = status_q;
    rnum_d       = rnum_q;
    rcnt_d       = rcnt_q;

    if (accept) begin
      func_d       = func_i;
      addr_d       = address_i;
      now_d        = time_now_i;
      num_d        = entry_number_i;
      key_d        = in_rule;
      rem_d        = count_q;
      kept_d       = '0;
      pos_d        = '0;
      removed_d    = '0;
      res_num_d    = '0;
      found_d      = 1'b0;
      res_status_d = ST_DONE;
      purge_d      = 1'b0;
      case (func_i)
        FUNC_CHECK: begin
          if ((time_now_i - last_purge_q) >= interval_q) begin
            purge_d      = 1'b1;
            last_purge_d = time_now_i;
          end
        end
        FUNC_APPEND: begin
          found_d = 1'b1;
          if (bad_rule) res_status_d = ST_ERROR;
          else if (32'(count_q) >= TABLE_DEPTH) res_status_d = ST_FULL;
          else count_d = count_q + CW'(1);
        end
        FUNC_DEL_SAME: begin
          if (bad_rule) begin
            found_d      = 1'b1;
            res_status_d = ST_ERROR;
          end
        end
        default: begin
          found_d = 1'b1;
          if (entry_number_i == 6'd0 || 32'(entry_number_i) > 32'(count_q)) begin
            res_status_d = ST_BAD_NUMBER;
          end
        end
      endcase
    end

    if (walking) begin
      rem_d = rem_q - CW'(1);
      pos_d = pos_q + CW'(1);
      if (keep) kept_d = kept_q + CW'(1);
      else if (func_q == FUNC_DEL_SAME) removed_d = removed_q + CW'(1);
      if (func_q == FUNC_CHECK && keep && !found_q) begin
        if (ev.err) begin
          found_d      = 1'b1;
          res_status_d = ST_ERROR;
        end else if (ev.hit) begin
          found_d      = 1'b1;
          res_status_d = ST_BANNED;
          res_num_d    = kept_q + CW'(1);
        end
      end
      if (rem_q == CW'(1)) count_d = keep ? kept_q + CW'(1) : kept_q;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      status_d    = fin_status;
      rnum_d      = (func_q == FUNC_CHECK && fin_status == ST_BANNED)
                  ? 6'(32'(res_num_q)) : 6'd0;
      rcnt_d      = (func_q == FUNC_DEL_SAME) ? 6'(32'(removed_q)) : 6'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      last_purge_q <= '0;
      interval_q   <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      last_purge_q <= last_purge_d;
      out_valid_q  <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) interval_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q        <= rem_d;
    kept_q       <= kept_d;
    pos_q        <= pos_d;
    removed_q    <= removed_d;
    res_num_q    <= res_num_d;
    func_q       <= func_d;
    addr_q       <= addr_d;
    now_q        <= now_d;
    num_q        <= num_d;
    key_q        <= key_d;
    purge_q      <= purge_d;
    found_q      <= found_d;
    res_status_q <= res_status_d;
    status_q     <= status_d;
    rnum_q       <= rnum_d;
    rcnt_q       <= rcnt_d;
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign rule_number_o   = rnum_q;
  assign removed_count_o = rcnt_q;

  `ASSERT_ALWAYS(a_count_bound, clk_i, rst_ni, 32'(count_q) <= TABLE_DEPTH)
  `ASSERT_ALWAYS(a_walk_nonempty, clk_i, rst_ni, !walking || rem_q != '0)
  `ASSERT_CLK(a_walk_end, clk_i, rst_ni, (walking && rem_q == CW'(1)) |=> state_q == S_DONE)
  `ASSERT_CLK(a_out_from_done, clk_i, rst_ni, $rose(out_valid_q) |-> $past(state_q == S_DONE))

endmodule
